@@ rtl/core/pfp_pkg.sv @@
// Package for the particulate frame parser.
// Holds the frame constants and the result type shared by the parser and the top level.
// Depends on nothing.
package pfp_pkg;

   localparam logic [7:0] HDR_FIRST  = 8'h42;
   localparam logic [7:0] HDR_SECOND = 8'h4D;
   localparam logic [15:0] HDR_SUM   = 16'(HDR_FIRST) + 16'(HDR_SECOND);
   localparam logic [4:0] POS_FIRST  = 5'd2;
   localparam logic [4:0] SUM_BYTES  = 5'd30;
   localparam logic [4:0] FRAME_LAST = 5'd31;
   localparam logic [4:0] CAPT_LAST  = 5'd15;
   localparam int unsigned NUM_WORDS = 7;

   typedef struct packed {
      logic [15:0] frame_length;
      logic [15:0] pm1_standard;
      logic [15:0] pm2p5_standard;
      logic [15:0] pm10p0_standard;
      logic [15:0] pm1_env;
      logic [15:0] pm2p5_env;
      logic [15:0] pm10p0_env;
      logic [15:0] received_sum;
      logic        checksum_ok;
   } pfp_result_type;

endpackage

@@ rtl/core/pfp_parser.sv @@
// Frame parser state machine for the particulate frame parser.
// Hunts for the header, sums and captures frame bytes, and forms one result per frame.
// Depends on pfp_pkg.
module pfp_parser
   import pfp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic [7:0]     rx_byte,
   output logic           res_valid,
   output pfp_result_type res
);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HDR2,
      PH_COLLECT
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [4:0]  pos_ff, pos_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  hold_ff, hold_in;
   logic [15:0] words_ff [NUM_WORDS];
   logic [15:0] words_in [NUM_WORDS];
   logic [4:0]  pos;
   logic [15:0] word;
   logic [2:0]  widx;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      hold_in   = hold_ff;
      words_in  = words_ff;
      res_valid = 1'b0;
      pos       = (pos_ff < POS_FIRST) ? FRAME_LAST : pos_ff;
      word      = {hold_ff, rx_byte};
      widx      = pos[3:1] - 3'd1;
      case (phase_ff)
         PH_HDR2: begin
            if (rx_byte == HDR_SECOND) begin
               phase_in = PH_COLLECT;
               pos_in   = POS_FIRST;
               sum_in   = HDR_SUM;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_COLLECT: begin
            if (pos < SUM_BYTES) begin
               sum_in = sum_ff + 16'(rx_byte);
            end
            if (!pos[0]) begin
               hold_in = rx_byte;
               pos_in  = pos + 5'd1;
            end else begin
               if (pos <= CAPT_LAST) begin
                  for (int k = 0; k < NUM_WORDS; k++) begin
                     if (widx == 3'(k)) begin
                        words_in[k] = word;
                     end
                  end
               end
               if (pos != FRAME_LAST) begin
                  pos_in = pos + 5'd1;
               end else begin
                  res_valid = 1'b1;
                  phase_in  = PH_HUNT;
                  pos_in    = 5'd0;
               end
            end
         end
         default: begin
            phase_in = (rx_byte == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
         end
      endcase
   end

   always_comb begin
      res.frame_length    = words_ff[0];
      res.pm1_standard    = words_ff[1];
      res.pm2p5_standard  = words_ff[2];
      res.pm10p0_standard = words_ff[3];
      res.pm1_env         = words_ff[4];
      res.pm2p5_env       = words_ff[5];
      res.pm10p0_env      = words_ff[6];
      res.received_sum    = word;
      res.checksum_ok     = (sum_ff == word);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         pos_ff   <= 5'd0;
         sum_ff   <= 16'd0;
         hold_ff  <= 8'd0;
         for (int k = 0; k < NUM_WORDS; k++) begin
            words_ff[k] <= 16'd0;
         end
      end else if (advance) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         hold_ff  <= hold_in;
         words_ff <= words_in;
      end
   end

endmodule

@@ rtl/core/particulate_frame_parser_unit.sv @@
// Top level of the particulate frame parser: input register, parser, result register.
// An accepted byte is held in the input register and parsed from there; a frame result is
// registered in the result register and shown on the rsp_ port. One byte is taken every cycle while results drain.
// A stalled result stalls the parser only when the next byte would also end a frame.
// Synchronous reset returns the parser to header hunting and empties both registers.
// Depends on pfp_pkg and pfp_parser.
module particulate_frame_parser_unit
   import pfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_frame_length,
   output logic [15:0] rsp_pm1_standard,
   output logic [15:0] rsp_pm2p5_standard,
   output logic [15:0] rsp_pm10p0_standard,
   output logic [15:0] rsp_pm1_env,
   output logic [15:0] rsp_pm2p5_env,
   output logic [15:0] rsp_pm10p0_env,
   output logic [15:0] rsp_received_sum,
   output logic        rsp_checksum_ok
);

   logic           stage_valid_ff, stage_valid_in;
   logic [7:0]     stage_byte_ff, stage_byte_in;
   logic           rsp_valid_ff, rsp_valid_in;
   pfp_result_type rsp_ff, rsp_in;
   logic           advance;
   logic           res_valid;
   pfp_result_type res;

   pfp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .rx_byte   (stage_byte_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   assign advance   = stage_valid_ff && (!res_valid || !rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_byte_in  = stage_byte_ff;
      if (req_valid && req_ready) begin
         stage_valid_in = 1'b1;
         stage_byte_in  = req_rx_byte;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance && res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      stage_byte_ff <= stage_byte_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_frame_length    = rsp_ff.frame_length;
   assign rsp_pm1_standard    = rsp_ff.pm1_standard;
   assign rsp_pm2p5_standard  = rsp_ff.pm2p5_standard;
   assign rsp_pm10p0_standard = rsp_ff.pm10p0_standard;
   assign rsp_pm1_env         = rsp_ff.pm1_env;
   assign rsp_pm2p5_env       = rsp_ff.pm2p5_env;
   assign rsp_pm10p0_env      = rsp_ff.pm10p0_env;
   assign rsp_received_sum    = rsp_ff.received_sum;
   assign rsp_checksum_ok     = rsp_ff.checksum_ok;

`ifndef SYNTHESIS
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (advance && res_valid) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while holding an item");

   a_ready_only_when_free: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (stage_valid_ff && res_valid && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without a blocked result");

   a_result_follows_parse: assert property (@(posedge clock) disable iff (reset)
      (advance && res_valid) |=> rsp_valid_ff)
      else $error("completed frame did not reach the result register");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !stage_valid_ff))
      else $error("registers not empty after reset");
`endif

endmodule

@@ dv/tb_particulate_frame_parser_unit.sv @@
// Testbench for particulate_frame_parser_unit: drives sensor bytes, predicts frame results
// with its own parser model or fixed table values, and checks every result field by field under random stalls.
// Depends on pfp_pkg and the parser RTL.
`timescale 1ns / 100ps

module tb_particulate_frame_parser_unit
   import pfp_pkg::*;
();

   localparam int BODY_BYTES = 28;
   localparam int RANDOM_BYTES = 1500;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 20;

   localparam pfp_result_type ZERO_FRAME = {{7{16'h0000}}, 16'h008F, 1'b1};
   localparam pfp_result_type FULL_FRAME = {{8{16'hFFFF}}, 1'b0};

   typedef enum logic [1:0] {HUNT_FIRST, HUNT_SECOND, COLLECT, PHASE_UNUSED} parse_phase_type;
   typedef enum {SUM_GOOD, SUM_BAD, SUM_FIXED} sum_mode_type;
   typedef enum {BODY_NONE, BODY_FILL, BODY_RANDOM} body_kind_type;

   typedef struct {
      logic [0:2][7:0] lead;
      int              nlead;
      body_kind_type   body;
      logic [7:0]      fill;
      sum_mode_type    mode;
      logic [15:0]     fixed_sum;
      bit              typed;
      pfp_result_type  want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_frame_length;
   logic [15:0] rsp_pm1_standard;
   logic [15:0] rsp_pm2p5_standard;
   logic [15:0] rsp_pm10p0_standard;
   logic [15:0] rsp_pm1_env;
   logic [15:0] rsp_pm2p5_env;
   logic [15:0] rsp_pm10p0_env;
   logic [15:0] rsp_received_sum;
   logic        rsp_checksum_ok;

   particulate_frame_parser_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_frame_length    (rsp_frame_length),
      .rsp_pm1_standard    (rsp_pm1_standard),
      .rsp_pm2p5_standard  (rsp_pm2p5_standard),
      .rsp_pm10p0_standard (rsp_pm10p0_standard),
      .rsp_pm1_env         (rsp_pm1_env),
      .rsp_pm2p5_env       (rsp_pm2p5_env),
      .rsp_pm10p0_env      (rsp_pm10p0_env),
      .rsp_received_sum    (rsp_received_sum),
      .rsp_checksum_ok     (rsp_checksum_ok)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   parse_phase_type phase_m;
   logic [4:0]      pos_m;
   logic [15:0]     sum_m;
   logic [7:0]      hold_m;
   logic [15:0]     words_m [8];

   pfp_result_type frame_q [$];
   pfp_result_type typed_want;
   bit             use_typed;
   logic [7:0]     frame_body [BODY_BYTES];
   dir_row_type    dir_rows [11];
   int             errors;
   int             bytes_sent;
   int             idle_cycles;
   int             stall_left;
   bit             sender_burst;
   bit             receiver_burst;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return $urandom_range(1, 3);
      end else if (r < 95) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, output pfp_result_type r);
      logic [4:0]  p;
      logic [15:0] w;
      r = '0;
      if (phase_m == HUNT_SECOND) begin
         if (b == HDR_SECOND) begin
            phase_m = COLLECT;
            pos_m = POS_FIRST;
            sum_m = HDR_SUM;
         end else begin
            phase_m = HUNT_FIRST;
         end
         return 1'b0;
      end
      if (phase_m != COLLECT) begin
         phase_m = (b == HDR_FIRST) ? HUNT_SECOND : HUNT_FIRST;
         return 1'b0;
      end
      p = (pos_m < POS_FIRST) ? FRAME_LAST : pos_m;
      if (p < SUM_BYTES) begin
         sum_m = sum_m + 16'(b);
      end
      if (!p[0]) begin
         hold_m = b;
         pos_m = p + 5'd1;
         return 1'b0;
      end
      w = {hold_m, b};
      if (p <= CAPT_LAST) begin
         words_m[p[4:1] - 4'd1] = w;
      end
      if (p != FRAME_LAST) begin
         pos_m = p + 5'd1;
         return 1'b0;
      end
      words_m[7] = w;
      r.frame_length    = words_m[0];
      r.pm1_standard    = words_m[1];
      r.pm2p5_standard  = words_m[2];
      r.pm10p0_standard = words_m[3];
      r.pm1_env         = words_m[4];
      r.pm2p5_env       = words_m[5];
      r.pm10p0_env      = words_m[6];
      r.received_sum    = w;
      r.checksum_ok     = (sum_m == w);
      phase_m = HUNT_FIRST;
      pos_m = 5'd0;
      return 1'b1;
   endfunction

   task automatic push_byte(input logic [7:0] b);
      int             gap;
      bit             made;
      pfp_result_type res;
      gap = (sender_burst || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      made = parse_byte(b, res);
      if (made) begin
         frame_q.push_back(use_typed ? typed_want : res);
      end
   endtask

   task automatic send_frame(input sum_mode_type mode, input logic [15:0] fixed_sum);
      logic [15:0] sum;
      logic [15:0] chk;
      sum = HDR_SUM;
      foreach (frame_body[k]) sum = sum + 16'(frame_body[k]);
      case (mode)
         SUM_GOOD: chk = sum;
         SUM_BAD:  chk = sum ^ 16'($urandom_range(1, 65535));
         default:  chk = fixed_sum;
      endcase
      push_byte(HDR_FIRST);
      push_byte(HDR_SECOND);
      foreach (frame_body[k]) push_byte(frame_body[k]);
      push_byte(chk[15:8]);
      push_byte(chk[7:0]);
   endtask

   task automatic check_word(input string name, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      pfp_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (frame_q.size() == 0) begin
               $display("%0t: unexpected item on rsp_, frame_length %h", $time,
                        rsp_frame_length);
               errors++;
            end else begin
               want = frame_q.pop_front();
               check_word("frame_length", want.frame_length, rsp_frame_length);
               check_word("pm1_standard", want.pm1_standard, rsp_pm1_standard);
               check_word("pm2p5_standard", want.pm2p5_standard, rsp_pm2p5_standard);
               check_word("pm10p0_standard", want.pm10p0_standard, rsp_pm10p0_standard);
               check_word("pm1_env", want.pm1_env, rsp_pm1_env);
               check_word("pm2p5_env", want.pm2p5_env, rsp_pm2p5_env);
               check_word("pm10p0_env", want.pm10p0_env, rsp_pm10p0_env);
               check_word("received_sum", want.received_sum, rsp_received_sum);
               check_word("checksum_ok", 16'(want.checksum_ok), 16'(rsp_checksum_ok));
            end
         end
         if ($urandom_range(0, 199) == 0) begin
            receiver_burst = !receiver_burst;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!receiver_burst && $urandom_range(0, 3) == 0) begin
               stall_left = pick_gap();
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no item accepted for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   initial begin : stimulus
      dir_row_type row;
      int       k;
      int       n;
      int       choice;
      logic [7:0] b;

      errors = 0;
      bytes_sent = 0;
      idle_cycles = 0;
      use_typed = 1'b0;
      sender_burst = 1'b0;
      receiver_burst = 1'b0;
      phase_m = HUNT_FIRST;
      pos_m = '0;
      sum_m = '0;
      hold_m = '0;
      foreach (words_m[i]) words_m[i] = '0;

      dir_rows = '{
         '{{8'h00, 8'hFF, 8'h00}, 2, BODY_NONE, 8'h00, SUM_GOOD, 16'h0000, 1'b0, '0},
         '{{HDR_FIRST, 8'h00, 8'h00}, 2, BODY_NONE, 8'h00, SUM_GOOD, 16'h0000, 1'b0, '0},
         '{{HDR_FIRST, HDR_FIRST, HDR_SECOND}, 3, BODY_NONE, 8'h00, SUM_GOOD, 16'h0000,
           1'b0, '0},
         '{{8'h00, 8'h00, 8'h00}, 0, BODY_FILL, 8'h00, SUM_GOOD, 16'h0000, 1'b1, ZERO_FRAME},
         '{{8'h00, 8'h00, 8'h00}, 0, BODY_FILL, 8'hFF, SUM_FIXED, 16'hFFFF, 1'b1, FULL_FRAME},
         '{{HDR_FIRST, 8'h00, 8'h00}, 1, BODY_FILL, 8'h00, SUM_GOOD, 16'h0000, 1'b0, '0},
         '{{8'h00, 8'h00, 8'h00}, 0, BODY_RANDOM, 8'h00, SUM_GOOD, 16'h0000, 1'b0, '0},
         '{{8'h00, 8'h00, 8'h00}, 0, BODY_RANDOM, 8'h00, SUM_BAD, 16'h0000, 1'b0, '0},
         '{{HDR_SECOND, 8'h00, 8'h00}, 2, BODY_RANDOM, 8'h00, SUM_GOOD, 16'h0000, 1'b0, '0},
         '{{8'h00, 8'h00, 8'h00}, 0, BODY_FILL, HDR_FIRST, SUM_GOOD, 16'h0000, 1'b0, '0},
         '{{8'h00, 8'h00, 8'h00}, 0, BODY_FILL, HDR_SECOND, SUM_BAD, 16'h0000, 1'b0, '0}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         for (k = 0; k < row.nlead; k++) begin
            push_byte(row.lead[k]);
         end
         if (row.body != BODY_NONE) begin
            foreach (frame_body[j]) begin
               frame_body[j] = (row.body == BODY_FILL) ? row.fill : 8'($urandom_range(0, 255));
            end
            use_typed = row.typed;
            typed_want = row.want;
            send_frame(row.mode, row.fixed_sum);
            use_typed = 1'b0;
         end
      end

      while (bytes_sent < RANDOM_BYTES) begin
         choice = $urandom_range(0, 99);
         if ($urandom_range(0, 7) == 0) begin
            sender_burst = !sender_burst;
         end
         if (choice < 85) begin
            foreach (frame_body[j]) begin
               case ($urandom_range(0, 5))
                  0:       frame_body[j] = 8'h00;
                  1:       frame_body[j] = 8'hFF;
                  default: frame_body[j] = 8'($urandom_range(0, 255));
               endcase
            end
            if ($urandom_range(0, 2) == 0) begin
               frame_body[0] = 8'h00;
               frame_body[1] = 8'h1C;
            end
            if (choice < 8) begin
               push_byte(HDR_FIRST);
            end
            send_frame(($urandom_range(0, 9) < 7) ? SUM_GOOD : SUM_BAD, 16'h0000);
         end else if (choice < 93) begin
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++) begin
               case ($urandom_range(0, 7))
                  0, 1:    b = HDR_FIRST;
                  2:       b = HDR_SECOND;
                  default: b = 8'($urandom_range(0, 255));
               endcase
               push_byte(b);
            end
         end else begin
            push_byte(HDR_FIRST);
            do b = 8'($urandom_range(0, 255)); while (b == HDR_SECOND);
            push_byte(b);
         end
      end

      req_valid <= 1'b0;
      while (frame_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
